### src/tksi_pkg.sv
// shared constants and types for the top-k sorted insert table
`default_nettype none
package tksi_pkg;

    localparam int CAPACITY = 10;

    localparam int SCORE_W = 32;
    localparam int TAG_W   = 16;
    localparam int RANK_W  = 6;
    localparam int OP_W    = 2;
    localparam int COUNT_W = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    // broadcast to every cell of the chain during the execute cycle
    typedef struct packed {
        logic               insert;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } t_cell_ctrl;

endpackage
`default_nettype wire

### src/tksi_cell.sv
// one rank of the sorted table: holds an entry, keeps it or takes the new or left entry
`default_nettype none
module tksi_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 4
) (
    input  wire                                 i_clk,
    input  tksi_pkg::t_cell_ctrl                i_ctrl,
    input  wire  [CNT_W-1:0]                    i_count,
    input  wire                                 i_left_keep,
    input  wire  [tksi_pkg::SCORE_W-1:0]        i_left_score,
    input  wire  [tksi_pkg::TAG_W-1:0]          i_left_tag,
    output logic                                o_keep,
    output logic [tksi_pkg::SCORE_W-1:0]        o_score,
    output logic [tksi_pkg::TAG_W-1:0]          o_tag,
    output logic [tksi_pkg::SCORE_W-1:0]        o_n_score
);

    logic [tksi_pkg::SCORE_W-1:0] r_score;
    logic [tksi_pkg::TAG_W-1:0]   r_tag;
    logic [tksi_pkg::SCORE_W-1:0] n_score;
    logic [tksi_pkg::TAG_W-1:0]   n_tag;
    logic                         occupied;
    logic                         take_new;

    assign occupied = (i_count > CNT_W'(INDEX));
    // equal scores stay ahead of the new entry
    assign o_keep   = occupied && (r_score >= i_ctrl.score);
    assign take_new = !o_keep && i_left_keep;

    always_comb begin
        n_score = r_score;
        n_tag   = r_tag;
        if (i_ctrl.insert && !o_keep) begin
            if (take_new) begin
                n_score = i_ctrl.score;
                n_tag   = i_ctrl.tag;
            end else begin
                n_score = i_left_score;
                n_tag   = i_left_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_score <= n_score;
        r_tag   <= n_tag;
    end

    assign o_score   = r_score;
    assign o_tag     = r_tag;
    assign o_n_score = n_score;

endmodule
`default_nettype wire

### src/top_k_sorted_insert_core.sv
// top level: command port, chain of table cells, read select and result register
// an item is taken at the edge with start high and busy low; busy stays high for one cycle
// the result strobe o_done is high for one cycle; it is busy passed through the done register
// no new item is taken while busy is high, in the execute cycle in which the cell chain updates
// the receiver cannot stall; reset empties the table and drops any item in flight
`default_nettype none
module top_k_sorted_insert_core #(
    parameter int CAPACITY = tksi_pkg::CAPACITY
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire  [tksi_pkg::OP_W-1:0]           i_opcode,
    input  wire  [tksi_pkg::SCORE_W-1:0]        i_score,
    input  wire  [tksi_pkg::TAG_W-1:0]          i_player_tag,
    input  wire  [tksi_pkg::RANK_W-1:0]         i_rank,
    output logic                                o_done,
    output logic [tksi_pkg::SCORE_W-1:0]        o_entry_score,
    output logic [tksi_pkg::TAG_W-1:0]          o_entry_tag,
    output logic                                o_entry_valid,
    output logic [tksi_pkg::COUNT_W-1:0]        o_entry_count,
    output logic [tksi_pkg::SCORE_W-1:0]        o_best_score
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic                           r_busy;
    logic                           r_done;
    logic [CNT_W-1:0]               r_count;
    logic [CNT_W-1:0]               n_count;
    logic [tksi_pkg::OP_W-1:0]      r_op;
    logic [tksi_pkg::SCORE_W-1:0]   r_score;
    logic [tksi_pkg::TAG_W-1:0]     r_tag;
    logic [tksi_pkg::RANK_W-1:0]    r_rank;

    logic [tksi_pkg::SCORE_W-1:0]   r_out_score;
    logic [tksi_pkg::TAG_W-1:0]     r_out_tag;
    logic                           r_out_valid;
    logic [tksi_pkg::COUNT_W-1:0]   r_out_count;
    logic [tksi_pkg::SCORE_W-1:0]   r_out_best;

    tksi_pkg::t_cell_ctrl           ctrl;
    logic [CAPACITY-1:0]            keep;
    logic [tksi_pkg::SCORE_W-1:0]   cell_score   [CAPACITY];
    logic [tksi_pkg::TAG_W-1:0]     cell_tag     [CAPACITY];
    logic [tksi_pkg::SCORE_W-1:0]   cell_n_score [CAPACITY];

    logic                           accept;
    logic                           rd_hit;
    logic [IDX_W-1:0]               rd_idx;

    assign accept = start && !r_busy;

    assign ctrl.insert = r_busy && (r_op == tksi_pkg::OP_INSERT);
    assign ctrl.score  = r_score;
    assign ctrl.tag    = r_tag;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                         left_keep;
            logic [tksi_pkg::SCORE_W-1:0] left_score;
            logic [tksi_pkg::TAG_W-1:0]   left_tag;
            if (g == 0) begin : g_head
                // head of the chain takes the new entry unless it keeps its own
                assign left_keep  = 1'b1;
                assign left_score = r_score;
                assign left_tag   = r_tag;
            end else begin : g_body
                assign left_keep  = keep[g-1];
                assign left_score = cell_score[g-1];
                assign left_tag   = cell_tag[g-1];
            end
            tksi_cell #(
                .INDEX (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (ctrl),
                .i_count      (r_count),
                .i_left_keep  (left_keep),
                .i_left_score (left_score),
                .i_left_tag   (left_tag),
                .o_keep       (keep[g]),
                .o_score      (cell_score[g]),
                .o_tag        (cell_tag[g]),
                .o_n_score    (cell_n_score[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        unique case (r_op)
            tksi_pkg::OP_INSERT: begin
                if (r_count != CAP_CNT) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            tksi_pkg::OP_CLEAR:  n_count = '0;
            tksi_pkg::OP_READ,
            tksi_pkg::OP_NOP:    n_count = r_count;
            default:             n_count = r_count;
        endcase
    end

    assign rd_hit = (r_op == tksi_pkg::OP_READ) &&
                    ({1'b0, r_rank} < tksi_pkg::COUNT_W'(r_count));
    assign rd_idx = r_rank[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= r_busy;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy  <= 1'b0;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_opcode;
            r_score <= i_score;
            r_tag   <= i_player_tag;
            r_rank  <= i_rank;
        end
        if (r_busy) begin
            r_out_valid <= rd_hit;
            r_out_score <= rd_hit ? cell_score[rd_idx] : '0;
            r_out_tag   <= rd_hit ? cell_tag[rd_idx] : '0;
            r_out_count <= tksi_pkg::COUNT_W'(n_count);
            // best entry after the step is the head cell's next value
            r_out_best  <= (n_count != '0) ? cell_n_score[0] : '0;
        end
    end

    assign busy          = r_busy;
    assign o_done        = r_done;
    assign o_entry_score = r_out_score;
    assign o_entry_tag   = r_out_tag;
    assign o_entry_valid = r_out_valid;
    assign o_entry_count = r_out_count;
    assign o_best_score  = r_out_best;

endmodule
`default_nettype wire

### tb/sv/top_k_sorted_insert_core_tb.sv
// testbench for the top-k sorted insert table: directed and random commands, checked against a table model
`default_nettype none
module top_k_sorted_insert_core_tb;

    typedef struct packed {
        logic [tksi_pkg::SCORE_W-1:0] entry_score;
        logic [tksi_pkg::TAG_W-1:0]   entry_tag;
        logic                         entry_valid;
        logic [tksi_pkg::COUNT_W-1:0] entry_count;
        logic [tksi_pkg::SCORE_W-1:0] best_score;
    } t_board_result;

    // mirrors the ranked table and holds the results still owed by the block
    class t_leaderboard_check;
        logic [tksi_pkg::SCORE_W-1:0] model_scores [tksi_pkg::CAPACITY];
        logic [tksi_pkg::TAG_W-1:0]   model_tags [tksi_pkg::CAPACITY];
        int                           model_count;
        t_board_result                due_results [$];
        int                           errors;
        int                           n_insert, n_full_insert, n_dropped;
        int                           n_read, n_hit, n_clear, n_nop, n_checked;

        function new();
            model_count  = 0;
            errors       = 0;
            n_insert = 0; n_full_insert = 0; n_dropped = 0;
            n_read = 0; n_hit = 0; n_clear = 0; n_nop = 0; n_checked = 0;
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function void note_cmd(logic [tksi_pkg::OP_W-1:0] op, logic [tksi_pkg::SCORE_W-1:0] sc,
                               logic [tksi_pkg::TAG_W-1:0] tg,
                               logic [tksi_pkg::RANK_W-1:0] rk);
            t_board_result r;
            int            pos;
            int            i;
            r = '0;
            case (op)
                tksi_pkg::OP_INSERT: begin
                    n_insert++;
                    if (model_count == tksi_pkg::CAPACITY) n_full_insert++;
                    // stable order: new entry goes after every equal or higher score
                    pos = 0;
                    while (pos < model_count && model_scores[pos] >= sc) pos++;
                    if (pos >= tksi_pkg::CAPACITY) begin
                        n_dropped++;
                    end else begin
                        i = (model_count < tksi_pkg::CAPACITY) ? model_count
                                                               : tksi_pkg::CAPACITY - 1;
                        while (i > pos) begin
                            model_scores[i] = model_scores[i-1];
                            model_tags[i]   = model_tags[i-1];
                            i--;
                        end
                        model_scores[pos] = sc;
                        model_tags[pos]   = tg;
                        if (model_count < tksi_pkg::CAPACITY) model_count++;
                    end
                end
                tksi_pkg::OP_READ: begin
                    n_read++;
                    if (rk < model_count) begin
                        n_hit++;
                        r.entry_score = model_scores[rk];
                        r.entry_tag   = model_tags[rk];
                        r.entry_valid = 1'b1;
                    end
                end
                tksi_pkg::OP_CLEAR: begin
                    n_clear++;
                    model_count = 0;
                end
                default: n_nop++;
            endcase
            r.entry_count = model_count[tksi_pkg::COUNT_W-1:0];
            r.best_score  = (model_count > 0) ? model_scores[0] : '0;
            due_results = {due_results, r};
        endfunction

        function void flag_field(string name, logic [63:0] want, logic [63:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        endfunction

        function void check_result(logic [tksi_pkg::SCORE_W-1:0] sc,
                                   logic [tksi_pkg::TAG_W-1:0] tg, logic v,
                                   logic [tksi_pkg::COUNT_W-1:0] cnt,
                                   logic [tksi_pkg::SCORE_W-1:0] best);
            t_board_result want;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: result strobe with no command outstanding", $time);
                return;
            end
            want = due_results.pop_front();
            n_checked++;
            if (sc !== want.entry_score)
                flag_field("entry_score", 64'(want.entry_score), 64'(sc));
            if (tg !== want.entry_tag)
                flag_field("entry_tag", 64'(want.entry_tag), 64'(tg));
            if (v !== want.entry_valid)
                flag_field("entry_valid", 64'(want.entry_valid), 64'(v));
            if (cnt !== want.entry_count)
                flag_field("entry_count", 64'(want.entry_count), 64'(cnt));
            if (best !== want.best_score)
                flag_field("best_score", 64'(want.best_score), 64'(best));
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [tksi_pkg::OP_W-1:0]    i_opcode;
    logic [tksi_pkg::SCORE_W-1:0] i_score;
    logic [tksi_pkg::TAG_W-1:0]   i_player_tag;
    logic [tksi_pkg::RANK_W-1:0]  i_rank;
    logic                         o_done;
    logic [tksi_pkg::SCORE_W-1:0] o_entry_score;
    logic [tksi_pkg::TAG_W-1:0]   o_entry_tag;
    logic                         o_entry_valid;
    logic [tksi_pkg::COUNT_W-1:0] o_entry_count;
    logic [tksi_pkg::SCORE_W-1:0] o_best_score;

    t_leaderboard_check table_sb;

    top_k_sorted_insert_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_score       (i_score),
        .i_player_tag  (i_player_tag),
        .i_rank        (i_rank),
        .o_done        (o_done),
        .o_entry_score (o_entry_score),
        .o_entry_tag   (o_entry_tag),
        .o_entry_valid (o_entry_valid),
        .o_entry_count (o_entry_count),
        .o_best_score  (o_best_score)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // outputs are stable mid-cycle, so results are taken on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_done)
            table_sb.check_result(o_entry_score, o_entry_tag, o_entry_valid,
                                  o_entry_count, o_best_score);
    end

    // called just after a rising edge; returns just after the transfer edge
    task automatic issue_cmd(input logic [tksi_pkg::OP_W-1:0] op,
                             input logic [tksi_pkg::SCORE_W-1:0] sc,
                             input logic [tksi_pkg::TAG_W-1:0] tg,
                             input logic [tksi_pkg::RANK_W-1:0] rk);
        start        <= 1'b1;
        i_opcode     <= op;
        i_score      <= sc;
        i_player_tag <= tg;
        i_rank       <= rk;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        table_sb.note_cmd(op, sc, tg, rk);
    endtask

    task automatic idle_gap();
        int p;
        int n;
        p = $urandom_range(0, 99);
        if (p < 50)      n = 0;
        else if (p < 85) n = $urandom_range(1, 3);
        else if (p < 97) n = $urandom_range(4, 10);
        else             n = $urandom_range(11, 40);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic random_cmd();
        int                           p;
        logic [tksi_pkg::OP_W-1:0]    op;
        logic [tksi_pkg::SCORE_W-1:0] sc;
        logic [tksi_pkg::RANK_W-1:0]  rk;
        p  = $urandom_range(0, 99);
        sc = $urandom();
        rk = tksi_pkg::RANK_W'($urandom_range(0, 63));
        if (p < 48) begin
            op = tksi_pkg::OP_INSERT;
            p  = $urandom_range(0, 99);
            // small scores give plenty of ties; the lowest held score tests the full-table edge
            if (p < 35)
                sc = $urandom_range(0, 15);
            else if (p < 45)
                sc = ($urandom_range(0, 1) != 0) ? '1 : '0;
            else if (p < 60 && table_sb.model_count > 0)
                sc = table_sb.model_scores[table_sb.model_count-1] +
                     $urandom_range(0, 2) - 1;
        end else if (p < 94) begin
            op = tksi_pkg::OP_READ;
            if ($urandom_range(0, 3) != 0)
                rk = tksi_pkg::RANK_W'($urandom_range(0, tksi_pkg::CAPACITY + 1));
        end else if (p < 97) begin
            op = tksi_pkg::OP_CLEAR;
        end else begin
            op = tksi_pkg::OP_NOP;
        end
        issue_cmd(op, sc, tksi_pkg::TAG_W'($urandom_range(0, 16'hFFFF)), rk);
    endtask

    initial begin
        #5_000_000;
        $display("timeout: block stopped responding");
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int k;
        int n;
        table_sb     = new();
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_opcode     = tksi_pkg::OP_NOP;
        i_score      = '0;
        i_player_tag = '0;
        i_rank       = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, then a full table with ties and the drop-out edge
        issue_cmd(tksi_pkg::OP_READ,   '0, '0, '0);                          idle_gap();
        issue_cmd(tksi_pkg::OP_CLEAR,  '0, '0, '0);                          idle_gap();
        issue_cmd(tksi_pkg::OP_NOP,    '1, '1, '1);                          idle_gap();
        issue_cmd(tksi_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, '0);         idle_gap();
        issue_cmd(tksi_pkg::OP_INSERT, 32'd0, 16'h0000, '1);                 idle_gap();
        issue_cmd(tksi_pkg::OP_INSERT, 32'd100, 16'd1, '0);                  idle_gap();
        issue_cmd(tksi_pkg::OP_INSERT, 32'd100, 16'd2, '0);
        issue_cmd(tksi_pkg::OP_INSERT, 32'd100, 16'd3, '0);
        issue_cmd(tksi_pkg::OP_READ,   '0, '0, 6'd2);
        issue_cmd(tksi_pkg::OP_READ,   '0, '0, 6'd3);                        idle_gap();
        issue_cmd(tksi_pkg::OP_INSERT, 32'd50, 16'd4, '0);
        issue_cmd(tksi_pkg::OP_INSERT, 32'd200, 16'd5, '0);
        issue_cmd(tksi_pkg::OP_INSERT, 32'd7, 16'd6, '0);
        issue_cmd(tksi_pkg::OP_INSERT, 32'd300, 16'd7, '0);
        issue_cmd(tksi_pkg::OP_INSERT, 32'd1, 16'd8, '0);                    idle_gap();
        issue_cmd(tksi_pkg::OP_INSERT, 32'd0, 16'd9, '0);
        issue_cmd(tksi_pkg::OP_INSERT, 32'd1, 16'd10, '0);
        issue_cmd(tksi_pkg::OP_READ,   '0, '0,
                  tksi_pkg::RANK_W'(tksi_pkg::CAPACITY - 1));
        issue_cmd(tksi_pkg::OP_READ,   '0, '0, tksi_pkg::RANK_W'(tksi_pkg::CAPACITY));
        issue_cmd(tksi_pkg::OP_READ,   '1, '1, 6'd63);                       idle_gap();
        issue_cmd(tksi_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'h5555, '0);
        issue_cmd(tksi_pkg::OP_READ,   '0, '0, 6'd1);                        idle_gap();
        issue_cmd(tksi_pkg::OP_CLEAR,  '1, '1, '1);
        issue_cmd(tksi_pkg::OP_READ,   '0, '0, '0);
        issue_cmd(tksi_pkg::OP_INSERT, 32'hAAAA_AAAA, 16'hAAAA, 6'h2A);     idle_gap();

        for (k = 0; k < 1200; k++) begin
            random_cmd();
            // every so often a stretch of back-to-back transfers
            if (k % 200 < 160) idle_gap();
        end
        start <= 1'b0;

        for (n = 0; n < 1000 && table_sb.outstanding() != 0; n++) @(posedge i_clk);
        if (table_sb.outstanding() != 0) begin
            $display("%0t: %0d results never arrived", $time, table_sb.outstanding());
            table_sb.errors += table_sb.outstanding();
        end
        repeat (8) @(posedge i_clk);

        $display("%0d results checked: %0d inserts (%0d into a full table, %0d dropped)",
                 table_sb.n_checked, table_sb.n_insert, table_sb.n_full_insert,
                 table_sb.n_dropped);
        $display("%0d reads (%0d within count), %0d clears, %0d no-ops, %0d field errors",
                 table_sb.n_read, table_sb.n_hit, table_sb.n_clear, table_sb.n_nop,
                 table_sb.errors);
        if (table_sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire
